>>> rtl/cic_charge_deposit_3d_macros.svh
// assertion macros for the charge deposition block
`ifndef CIC_CHARGE_DEPOSIT_3D_MACROS_SVH
`define CIC_CHARGE_DEPOSIT_3D_MACROS_SVH

// same-cycle implication under reset
`define CCD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under reset
`define CCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/ccd_pkg.sv
// shared types, constants and helpers for the charge deposition block
`timescale 1ns / 1ps
package ccd_pkg;

    localparam int MAX_NX     = 32;
    localparam int MAX_NY     = 32;
    localparam int MAX_NZ     = 32;
    localparam int GRID_DEPTH = MAX_NX * MAX_NY * MAX_NZ;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);
    localparam int NODE_W     = 5;
    localparam int EXT_W      = 6;
    localparam int POS_W      = 48;
    localparam int INV_W      = 32;
    localparam int ACC_W      = 48;
    localparam int FRAC_W     = 16;
    localparam int WT_W       = 17;
    localparam int CFG_W      = 32;
    localparam int MOD_STEPS  = POS_W;
    localparam int STEP_W     = $clog2(MOD_STEPS);

    typedef enum logic [1:0] {
        ACT_DEPOSIT = 2'd0,
        ACT_READ    = 2'd1,
        ACT_CLEAR   = 2'd2
    } t_action;

    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_NX    = 3'd1;
    localparam logic [2:0] CFG_NY    = 3'd2;
    localparam logic [2:0] CFG_NZ    = 3'd3;
    localparam logic [2:0] CFG_INVX  = 3'd4;
    localparam logic [2:0] CFG_INVY  = 3'd5;
    localparam logic [2:0] CFG_INVZ  = 3'd6;
    localparam logic [2:0] CFG_SCALE = 3'd7;

    typedef struct packed {
        logic              load;
        logic              ax_lo;
        logic              ax_hi;
        logic              ax_sum;
        logic              ax_mod;
        logic              ax_done;
        logic [1:0]        axis;
        logic              cn_m1;
        logic              cn_m2;
        logic              cn_m3;
        logic              cn_m4;
        logic              cn_acc;
        logic [2:0]        corner;
        logic              clr_wr;
        logic [ADDR_W-1:0] clr_addr;
        logic              rd_issue;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic [EXT_W-1:0] ext_clamp(input logic [EXT_W-1:0] v, input int maxv);
        logic [EXT_W-1:0] r;
        r = v;
        if (v < EXT_W'(3)) r = EXT_W'(3);
        else if (int'(v) > maxv) r = EXT_W'(maxv);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] node_addr(input logic [NODE_W-1:0] x,
                                                    input logic [NODE_W-1:0] y,
                                                    input logic [NODE_W-1:0] z);
        return ADDR_W'(x) + ADDR_W'(MAX_NX) * (ADDR_W'(y) + ADDR_W'(MAX_NY) * ADDR_W'(z));
    endfunction

endpackage

>>> rtl/ccd_ctrl.sv
// sequencer for deposit, read and clear actions
`timescale 1ns / 1ps
`include "cic_charge_deposit_3d_macros.svh"
module ccd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_action,
    input  logic          i_alive,
    input  ccd_pkg::t_sts i_sts,
    output ccd_pkg::t_cmd o_cmd
);
    import ccd_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_AX_LO, S_AX_HI, S_AX_SUM, S_AX_MOD, S_AX_DONE,
        S_CN_M1, S_CN_M2, S_CN_M3, S_CN_M4, S_CN_ACC, S_RD_ISSUE, S_RD_WAIT, S_RD_OUT
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr;
    logic [1:0]          r_axis;
    logic [STEP_W-1:0]   r_step;
    logic [2:0]          r_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_axis   <= '0;
            r_step   <= '0;
            r_corner <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(GRID_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        case (i_action)
                            ACT_DEPOSIT: begin
                                if (i_alive) begin
                                    r_state <= S_AX_LO;
                                    r_axis  <= '0;
                                end
                            end
                            ACT_READ: r_state <= S_RD_ISSUE;
                            ACT_CLEAR: begin
                                r_state <= S_CLEAR;
                                r_clr   <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_AX_LO:  r_state <= S_AX_HI;
                S_AX_HI:  r_state <= S_AX_SUM;
                S_AX_SUM: begin
                    r_state <= S_AX_MOD;
                    r_step  <= '0;
                end
                S_AX_MOD: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(MOD_STEPS - 1)) r_state <= S_AX_DONE;
                end
                S_AX_DONE: begin
                    if (r_axis == 2'd2) begin
                        r_state  <= S_CN_M1;
                        r_corner <= '0;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_AX_LO;
                    end
                end
                S_CN_M1: r_state <= S_CN_M2;
                S_CN_M2: r_state <= S_CN_M3;
                S_CN_M3: r_state <= S_CN_M4;
                S_CN_M4: r_state <= S_CN_ACC;
                S_CN_ACC: begin
                    if (r_corner == 3'd7) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_corner <= r_corner + 3'd1;
                        r_state  <= S_CN_M1;
                    end
                end
                S_RD_ISSUE: r_state <= S_RD_WAIT;
                S_RD_WAIT:  r_state <= S_RD_OUT;
                S_RD_OUT: begin
                    if (i_sts.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.ax_lo    = (r_state == S_AX_LO);
        o_cmd.ax_hi    = (r_state == S_AX_HI);
        o_cmd.ax_sum   = (r_state == S_AX_SUM);
        o_cmd.ax_mod   = (r_state == S_AX_MOD);
        o_cmd.ax_done  = (r_state == S_AX_DONE);
        o_cmd.axis     = r_axis;
        o_cmd.cn_m1    = (r_state == S_CN_M1);
        o_cmd.cn_m2    = (r_state == S_CN_M2);
        o_cmd.cn_m3    = (r_state == S_CN_M3);
        o_cmd.cn_m4    = (r_state == S_CN_M4);
        o_cmd.cn_acc   = (r_state == S_CN_ACC);
        o_cmd.corner   = r_corner;
        o_cmd.clr_wr   = (r_state == S_CLEAR);
        o_cmd.clr_addr = r_clr;
        o_cmd.rd_issue = (r_state == S_RD_ISSUE);
        o_cmd.out_load = (r_state == S_RD_OUT) && i_sts.out_free;
    end

    `CCD_ASSERT_NOW(a_load_free, o_cmd.out_load, i_sts.out_free)
    `CCD_ASSERT_NEXT(a_clear_end, (r_state == S_CLEAR) && (r_clr == ADDR_W'(GRID_DEPTH - 1)), r_state == S_IDLE)
    `CCD_ASSERT_NEXT(a_corner_start, (r_state == S_AX_DONE) && (r_axis == 2'd2), (r_state == S_CN_M1) && (r_corner == 3'd0))
endmodule

>>> rtl/ccd_dp.sv
// datapath: config, axis mapping, weight products and grid memory
`timescale 1ns / 1ps
module ccd_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ccd_pkg::t_cmd              i_cmd,
    output ccd_pkg::t_sts              o_sts,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [ccd_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [ccd_pkg::POS_W-1:0]  i_pos_x,
    input  logic [ccd_pkg::POS_W-1:0]  i_pos_y,
    input  logic [ccd_pkg::POS_W-1:0]  i_pos_z,
    input  logic [ccd_pkg::NODE_W-1:0] i_node_x,
    input  logic [ccd_pkg::NODE_W-1:0] i_node_y,
    input  logic [ccd_pkg::NODE_W-1:0] i_node_z,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ccd_pkg::ACC_W-1:0]  o_node_charge,
    output logic                       o_saturated
);
    import ccd_pkg::*;

    logic                     r_mode;
    logic [EXT_W-1:0]         r_nx, r_ny, r_nz;
    logic [INV_W-1:0]         r_inv [3];
    logic [CFG_W-1:0]         r_scale;

    logic [POS_W-1:0]         r_pos [3];
    logic [NODE_W-1:0]        r_node_x, r_node_y, r_node_z;

    logic [55:0]              r_plo, r_phi;
    logic [POS_W-1:0]         r_iq;
    logic [FRAC_W-1:0]        r_frac;
    logic [NODE_W-1:0]        r_ilo, r_rem;
    logic                     r_big, r_neg;
    logic [NODE_W-1:0]        r_lo [3];
    logic [NODE_W-1:0]        r_hi [3];
    logic [WT_W-1:0]          r_f [3];

    logic [32:0]              r_wxy;
    logic [48:0]              r_p3;
    logic [64:0]              r_prod;
    logic [34:0]              r_mag;
    logic [1:0]               r_nb;
    logic [ADDR_W-1:0]        r_addr;

    logic [ACC_W-1:0]         mem [GRID_DEPTH];
    logic [ACC_W-1:0]         r_rdata;
    logic                     r_sat;
    logic                     r_out_valid;
    logic [ACC_W-1:0]         r_out_charge;
    logic                     r_out_sat;

    logic [EXT_W-1:0]         ext [3];
    logic [POS_W-1:0]         sel_pos, mag_pos;
    logic                     sel_neg;
    logic [EXT_W-1:0]         sel_ext;
    logic [79:0]              psum;
    logic [POS_W-1:0]         ival;
    logic [EXT_W-1:0]         mod_t;
    logic [NODE_W-1:0]        nm1, nm2, ax_i, ax_h;
    logic [WT_W-1:0]          ax_f;
    logic [WT_W-1:0]          wx, wy, wz;
    logic [NODE_W-1:0]        cx, cy, cz;
    logic [1:0]               nb;
    logic [32:0]              shape;
    logic                     cs_neg;
    logic [CFG_W-1:0]         cmag;
    logic [EXT_W-1:0]         sh;
    logic [65:0]              rnd;
    logic [49:0]              q50, sum50;
    logic [ACC_W-1:0]         acc_val;
    logic                     acc_ovf;
    logic                     in_range;
    logic                     mem_we, mem_re;
    logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
    logic [ACC_W-1:0]         mem_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b1;
            r_nx     <= EXT_W'(32);
            r_ny     <= EXT_W'(32);
            r_nz     <= EXT_W'(32);
            r_inv[0] <= INV_W'(65536);
            r_inv[1] <= INV_W'(65536);
            r_inv[2] <= INV_W'(65536);
            r_scale  <= CFG_W'(65536);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:  r_mode   <= i_cfg_data[0];
                CFG_NX:    r_nx     <= i_cfg_data[EXT_W-1:0];
                CFG_NY:    r_ny     <= i_cfg_data[EXT_W-1:0];
                CFG_NZ:    r_nz     <= i_cfg_data[EXT_W-1:0];
                CFG_INVX:  r_inv[0] <= i_cfg_data;
                CFG_INVY:  r_inv[1] <= i_cfg_data;
                CFG_INVZ:  r_inv[2] <= i_cfg_data;
                CFG_SCALE: r_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ext[0] = ext_clamp(r_nx, MAX_NX);
    assign ext[1] = ext_clamp(r_ny, MAX_NY);
    assign ext[2] = ext_clamp(r_nz, MAX_NZ);

    // axis mapping
    always_comb begin
        sel_pos = r_pos[i_cmd.axis];
        sel_ext = ext[i_cmd.axis];
        sel_neg = sel_pos[POS_W-1];
        mag_pos = sel_neg ? (POS_W'(0) - sel_pos) : sel_pos;
        psum    = {r_phi, 24'd0} + {24'd0, r_plo} + (sel_neg ? 80'hFFFF : 80'd0);
        ival    = psum[79:32];
        mod_t   = {r_rem, r_iq[POS_W-1]};
        nm1     = NODE_W'(sel_ext - EXT_W'(1));
        nm2     = NODE_W'(sel_ext - EXT_W'(2));
        if (r_mode) begin
            if (r_neg && (r_frac != '0)) begin
                ax_i = NODE_W'(nm1 - r_rem);
                ax_f = WT_W'(65536) - {1'b0, r_frac};
            end else if (r_neg && (r_rem != '0)) begin
                ax_i = NODE_W'(sel_ext - {1'b0, r_rem});
                ax_f = '0;
            end else begin
                ax_i = r_rem;
                ax_f = {1'b0, r_frac};
            end
            ax_h = ({1'b0, ax_i} + EXT_W'(1) == sel_ext) ? '0 : NODE_W'(ax_i + NODE_W'(1));
        end else begin
            if (r_neg) begin
                ax_i = '0;
                ax_f = '0;
            end else if (r_big) begin
                ax_i = nm2;
                ax_f = WT_W'(65536);
            end else begin
                ax_i = r_ilo;
                ax_f = {1'b0, r_frac};
            end
            ax_h = NODE_W'(ax_i + NODE_W'(1));
        end
    end

    // corner weights and accumulation
    always_comb begin
        wx     = i_cmd.corner[0] ? r_f[0] : WT_W'(65536) - r_f[0];
        wy     = i_cmd.corner[1] ? r_f[1] : WT_W'(65536) - r_f[1];
        wz     = i_cmd.corner[2] ? r_f[2] : WT_W'(65536) - r_f[2];
        cx     = i_cmd.corner[0] ? r_hi[0] : r_lo[0];
        cy     = i_cmd.corner[1] ? r_hi[1] : r_lo[1];
        cz     = i_cmd.corner[2] ? r_hi[2] : r_lo[2];
        nb     = '0;
        if (!r_mode) begin
            nb = 2'((cx == '0) || (cx == NODE_W'(ext[0] - EXT_W'(1))))
               + 2'((cy == '0) || (cy == NODE_W'(ext[1] - EXT_W'(1))))
               + 2'((cz == '0) || (cz == NODE_W'(ext[2] - EXT_W'(1))));
        end
        shape  = 33'((r_p3 + 49'd32768) >> 16);
        cs_neg = r_scale[CFG_W-1];
        cmag   = cs_neg ? (CFG_W'(0) - r_scale) : r_scale;
        sh     = EXT_W'(32) - {4'd0, r_nb};
        rnd    = {1'b0, r_prod} + (66'd1 << (sh - EXT_W'(1)));
        q50    = cs_neg ? (50'd0 - {15'd0, r_mag}) : {15'd0, r_mag};
        sum50  = {{2{r_rdata[ACC_W-1]}}, r_rdata} + q50;
        acc_ovf = !((sum50[49] == sum50[48]) && (sum50[48] == sum50[47]));
        if (acc_ovf) acc_val = sum50[49] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else         acc_val = sum50[ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_node_x <= i_node_x;
            r_node_y <= i_node_y;
            r_node_z <= i_node_z;
        end
        if (i_cmd.ax_lo) r_plo <= mag_pos[23:0] * r_inv[i_cmd.axis];
        if (i_cmd.ax_hi) r_phi <= mag_pos[47:24] * r_inv[i_cmd.axis];
        if (i_cmd.ax_sum) begin
            r_iq   <= ival;
            r_frac <= psum[31:16];
            r_ilo  <= ival[NODE_W-1:0];
            r_big  <= (|ival[POS_W-1:NODE_W]) || (ival[NODE_W-1:0] >= nm1);
            r_neg  <= sel_neg;
            r_rem  <= '0;
        end
        if (i_cmd.ax_mod) begin
            r_rem <= (mod_t >= sel_ext) ? NODE_W'(mod_t - sel_ext) : mod_t[NODE_W-1:0];
            r_iq  <= {r_iq[POS_W-2:0], 1'b0};
        end
        if (i_cmd.ax_done) begin
            r_lo[i_cmd.axis] <= ax_i;
            r_hi[i_cmd.axis] <= ax_h;
            r_f[i_cmd.axis]  <= ax_f;
        end
        if (i_cmd.cn_m1) r_wxy <= wx * wy;
        if (i_cmd.cn_m2) begin
            r_p3   <= r_wxy * wz;
            r_addr <= node_addr(cx, cy, cz);
            r_nb   <= nb;
        end
        if (i_cmd.cn_m3) r_prod <= cmag * shape;
        if (i_cmd.cn_m4) r_mag  <= 35'(rnd >> sh);
    end

    // grid memory
    assign mem_we    = i_cmd.clr_wr || i_cmd.cn_acc;
    assign mem_waddr = i_cmd.clr_wr ? i_cmd.clr_addr : r_addr;
    assign mem_wdata = i_cmd.clr_wr ? '0 : acc_val;
    assign mem_re    = i_cmd.cn_m4 || i_cmd.rd_issue;
    assign mem_raddr = i_cmd.rd_issue ? node_addr(r_node_x, r_node_y, r_node_z) : r_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_cmd.clr_wr) begin
            r_sat <= 1'b0;
        end else if (i_cmd.cn_acc && acc_ovf) begin
            r_sat <= 1'b1;
        end
    end

    // output register
    assign in_range = ({1'b0, r_node_x} < ext[0]) && ({1'b0, r_node_y} < ext[1])
                   && ({1'b0, r_node_z} < ext[2]);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_charge <= in_range ? r_rdata : '0;
            r_out_sat    <= r_sat;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_node_charge = r_out_charge;
    assign o_saturated   = r_out_sat;
endmodule

>>> rtl/cic_charge_deposit_3d.sv
// top level of the 3d cloud-in-cell charge deposition block
//
// input channel i_in_valid / o_in_ready carries one item: an action with
// particle position, alive flag and node index. action deposit adds the 8
// trilinear shares of a live particle into a 32x32x32 grid of 48-bit
// saturating accumulators; action read returns one node and the sticky
// saturation flag; action clear zeroes the grid and the flag.
// only a read gives a result, on o_out_valid / i_out_ready.
// one item is worked at a time. a live deposit runs, per axis, two 24x32
// partial products, one sum and 48 one-bit steps of the periodic modulo,
// and then the 8 read-modify-write updates, one per node, through the single
// grid memory. a read passes an issue state and a wait state and then
// loads the output register; dead deposits and unused actions do no work.
// after reset and after a clear every grid node is swept, one node per
// cycle, while no item is taken; config writes are taken at any time.
// a read result waits in the output register while the receiver stalls and
// the next item is still taken; a later read waits until that slot frees.
`timescale 1ns / 1ps
module cic_charge_deposit_3d (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [ccd_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_action,
    input  logic [ccd_pkg::POS_W-1:0]  i_pos_x,
    input  logic [ccd_pkg::POS_W-1:0]  i_pos_y,
    input  logic [ccd_pkg::POS_W-1:0]  i_pos_z,
    input  logic                       i_alive,
    input  logic [ccd_pkg::NODE_W-1:0] i_node_x,
    input  logic [ccd_pkg::NODE_W-1:0] i_node_y,
    input  logic [ccd_pkg::NODE_W-1:0] i_node_z,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ccd_pkg::ACC_W-1:0]  o_node_charge,
    output logic                       o_saturated
);
    import ccd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ccd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_alive    (i_alive),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ccd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_node_x      (i_node_x),
        .i_node_y      (i_node_y),
        .i_node_z      (i_node_z),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_node_charge (o_node_charge),
        .o_saturated   (o_saturated)
    );
endmodule

>>> sim/tb.sv
// testbench for the 3d cloud-in-cell charge deposition block: grid predictor and read checks
`timescale 1ns / 1ps
module tb;
    import ccd_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
    localparam longint ACC_LO = -(64'sd1 <<< 47);
    localparam int SETTLE = 300;

    typedef struct {
        logic [ACC_W-1:0] charge;
        logic             sat;
    } t_read_exp;

    class t_charge_grid_model;
        bit               periodic;
        logic [EXT_W-1:0] raw_nx, raw_ny, raw_nz;
        logic [31:0]      inv_x, inv_y, inv_z;
        longint           scale;
        longint           grid[GRID_DEPTH];
        bit               sat_seen;
        t_read_exp        pending[$];
        int               errors, deposits, reads, clears;

        function new();
            periodic = 1; raw_nx = 32; raw_ny = 32; raw_nz = 32;
            inv_x = 65536; inv_y = 65536; inv_z = 65536; scale = 65536;
            sat_seen = 0;
            foreach (grid[i]) grid[i] = 0;
        endfunction

        function int extent(logic [EXT_W-1:0] v, int maxv);
            if (v < 3) return 3;
            if (int'(v) > maxv) return maxv;
            return int'(v);
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                CFG_MODE:  periodic = d[0];
                CFG_NX:    raw_nx = d[EXT_W-1:0];
                CFG_NY:    raw_ny = d[EXT_W-1:0];
                CFG_NZ:    raw_nz = d[EXT_W-1:0];
                CFG_INVX:  inv_x = d;
                CFG_INVY:  inv_y = d;
                CFG_INVZ:  inv_z = d;
                CFG_SCALE: scale = longint'(signed'(d));
                default: ;
            endcase
        endfunction

        function void map_axis(logic [POS_W-1:0] pos, logic [31:0] inv, int n,
                               output int lo, output int hi, output longint unsigned fr);
            bit neg;
            longint unsigned m, low, g, span, r, top, f;
            int i;
            neg = pos[POS_W-1];
            m = neg ? ((64'd1 << 48) - {16'd0, pos}) : {16'd0, pos};
            low = m * {48'd0, inv[15:0]};
            g = m * {48'd0, inv[31:16]} + (low >> 16);
            if (neg && low[15:0] != 0) g = g + 1;
            if (periodic) begin
                span = longint'(n) << 16;
                r = g % span;
                if (neg && r != 0) r = span - r;
                i = int'(r >> 16);
                f = r & 64'hFFFF;
                lo = i;
                hi = (i + 1 == n) ? 0 : i + 1;
            end else begin
                top = longint'(n - 1) << 16;
                if (neg) g = 0;
                if (g > top) g = top;
                i = int'(g >> 16);
                if (i > n - 2) i = n - 2;
                f = g - (longint'(i) << 16);
                if (f > 65536) f = 65536;
                lo = i;
                hi = i + 1;
            end
            fr = f;
        endfunction

        function void deposit(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                              logic [POS_W-1:0] pz);
            int n[3], lo[3], hi[3], node[3], sh, idx;
            longint unsigned fr[3], w[3][2], shape, mag, cmag;
            longint s;
            bit neg;
            n[0] = extent(raw_nx, MAX_NX);
            n[1] = extent(raw_ny, MAX_NY);
            n[2] = extent(raw_nz, MAX_NZ);
            map_axis(px, inv_x, n[0], lo[0], hi[0], fr[0]);
            map_axis(py, inv_y, n[1], lo[1], hi[1], fr[1]);
            map_axis(pz, inv_z, n[2], lo[2], hi[2], fr[2]);
            for (int k = 0; k < 3; k++) begin
                w[k][0] = 65536 - fr[k];
                w[k][1] = fr[k];
            end
            neg = scale < 0;
            cmag = neg ? longint'(-scale) : longint'(scale);
            for (int c = 0; c < 8; c++) begin
                sh = 32;
                shape = (w[0][c[0]] * w[1][c[1]] * w[2][c[2]] + 32768) >> 16;
                for (int k = 0; k < 3; k++) begin
                    node[k] = c[k] ? hi[k] : lo[k];
                    if (!periodic && (node[k] == 0 || node[k] == n[k] - 1)) sh--;
                end
                mag = (cmag * shape + (64'd1 << (sh - 1))) >> sh;
                idx = node[0] + MAX_NX * (node[1] + MAX_NY * node[2]);
                s = grid[idx] + (neg ? -longint'(mag) : longint'(mag));
                if (s > ACC_HI) begin s = ACC_HI; sat_seen = 1; end
                if (s < ACC_LO) begin s = ACC_LO; sat_seen = 1; end
                grid[idx] = s;
            end
        endfunction

        function void note_item(logic [1:0] act, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                logic [POS_W-1:0] pz, logic alive, logic [NODE_W-1:0] x,
                                logic [NODE_W-1:0] y, logic [NODE_W-1:0] z);
            t_read_exp e;
            case (act)
                ACT_DEPOSIT: if (alive) begin
                    deposit(px, py, pz);
                    deposits++;
                end
                ACT_READ: begin
                    e.charge = '0;
                    if (x < extent(raw_nx, MAX_NX) && y < extent(raw_ny, MAX_NY) &&
                        z < extent(raw_nz, MAX_NZ))
                        e.charge = ACC_W'(grid[int'(x) + MAX_NX * (int'(y) + MAX_NY * int'(z))]);
                    e.sat = sat_seen;
                    pending.push_back(e);
                end
                ACT_CLEAR: begin
                    foreach (grid[i]) grid[i] = 0;
                    sat_seen = 0;
                    clears++;
                end
                default: ;
            endcase
        endfunction

        task mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_read(logic [ACC_W-1:0] charge, logic sat);
            t_read_exp e;
            if (pending.size() == 0) begin
                mismatch("read result with nothing expected");
            end else begin
                e = pending.pop_front();
                reads++;
                if (charge !== e.charge)
                    mismatch($sformatf("node_charge got %h want %h", charge, e.charge));
                if (sat !== e.sat)
                    mismatch($sformatf("saturated got %b want %b", sat, e.sat));
            end
        endtask
    endclass

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                i_cfg_we = 0;
    logic [2:0]          i_cfg_idx = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_in_valid = 0;
    logic                o_in_ready;
    logic [1:0]          i_action = '0;
    logic [POS_W-1:0]    i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic                i_alive = 0;
    logic [NODE_W-1:0]   i_node_x = '0, i_node_y = '0, i_node_z = '0;
    logic                o_out_valid;
    logic                i_out_ready = 0;
    logic [ACC_W-1:0]    o_node_charge;
    logic                o_saturated;

    t_charge_grid_model grid_model = new();
    bit quiet = 0;

    cic_charge_deposit_3d u_dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk)
        i_out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 38);

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            grid_model.note_item(i_action, i_pos_x, i_pos_y, i_pos_z, i_alive,
                                 i_node_x, i_node_y, i_node_z);
        if (i_rst_n && o_out_valid && i_out_ready)
            grid_model.check_read(o_node_charge, o_saturated);
    end

    task automatic send_item(logic [1:0] act, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                             logic [POS_W-1:0] pz, logic alive, logic [NODE_W-1:0] x,
                             logic [NODE_W-1:0] y, logic [NODE_W-1:0] z);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < 38) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_action <= act;
        i_pos_x <= px; i_pos_y <= py; i_pos_z <= pz;
        i_alive <= alive;
        i_node_x <= x; i_node_y <= y; i_node_z <= z;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // wait until the block is idle again and every read is checked
    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (grid_model.pending.size() != 0 || !o_in_ready) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_regs(bit mode, int nx, int ny, int nz, logic [31:0] ix,
                            logic [31:0] iy, logic [31:0] iz, logic [31:0] sc);
        logic [31:0] vals[8];
        vals = '{32'(mode), 32'(nx), 32'(ny), 32'(nz), ix, iy, iz, sc};
        for (int k = 0; k < 8; k++) begin
            i_cfg_we <= 1;
            i_cfg_idx <= 3'(k);
            i_cfg_data <= vals[k];
            grid_model.write_reg(3'(k), vals[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 0;
    endtask

    function automatic logic [POS_W-1:0] pick_pos();
        logic [POS_W-1:0] p;
        case ($urandom_range(0, 9))
            0: p = POS_W'({$urandom, $urandom});
            9: case ($urandom_range(0, 3))
                0: p = {1'b0, {(POS_W-1){1'b1}}};
                1: p = {1'b1, {(POS_W-1){1'b0}}};
                2: p = '0;
                default: p = '1;
            endcase
            default: p = POS_W'(longint'($urandom_range(0, 80 << 16)) - (40 << 16));
        endcase
        return p;
    endfunction

    function automatic logic [NODE_W-1:0] pick_node(int n);
        return $urandom_range(0, 1) ? NODE_W'($urandom_range(0, 31))
                                    : NODE_W'($urandom_range(0, n - 1));
    endfunction

    task automatic random_items(int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 999);
            if (r < 600)
                send_item(ACT_DEPOSIT, pick_pos(), pick_pos(), pick_pos(),
                          $urandom_range(0, 9) != 0, NODE_W'($urandom), NODE_W'($urandom),
                          NODE_W'($urandom));
            else if (r < 965)
                send_item(ACT_READ, POS_W'({$urandom, $urandom}),
                          POS_W'({$urandom, $urandom}), POS_W'({$urandom, $urandom}),
                          1'($urandom),
                          pick_node(grid_model.extent(grid_model.raw_nx, MAX_NX)),
                          pick_node(grid_model.extent(grid_model.raw_ny, MAX_NY)),
                          pick_node(grid_model.extent(grid_model.raw_nz, MAX_NZ)));
            else if (r < 995)
                send_item(ACT_UNUSED, pick_pos(), pick_pos(), pick_pos(), 1'($urandom),
                          NODE_W'($urandom), NODE_W'($urandom), NODE_W'($urandom));
            else
                send_item(ACT_CLEAR, pick_pos(), pick_pos(), pick_pos(), 1'($urandom),
                          NODE_W'($urandom), NODE_W'($urandom), NODE_W'($urandom));
        end
    endtask

    initial begin
        logic [POS_W-1:0] pmax, pmin, half;
        pmax = {1'b0, {(POS_W-1){1'b1}}};
        pmin = {1'b1, {(POS_W-1){1'b0}}};
        half = POS_W'(longint'(31) * 65536 + 32768);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // defaults: periodic wrap over the full grid
        send_item(ACT_DEPOSIT, '0, '0, '0, 1, '0, '0, '0);
        send_item(ACT_READ, '0, '0, '0, 0, 5'd0, 5'd0, 5'd0);
        send_item(ACT_DEPOSIT, half, half, half, 1, '0, '0, '0);
        send_item(ACT_DEPOSIT, pmax, pmin, pmax, 1, '1, '1, '1);
        send_item(ACT_DEPOSIT, pmin, pmax, -48'sd16384, 1, '0, '0, '0);
        send_item(ACT_DEPOSIT, pmax, pmax, pmax, 0, '1, '1, '1);
        send_item(ACT_UNUSED, pmax, pmax, pmax, 1, '1, '1, '1);
        send_item(ACT_READ, '1, '1, '1, 1, 5'd31, 5'd31, 5'd31);
        send_item(ACT_READ, '0, '0, '0, 0, 5'd0, 5'd0, 5'd31);
        send_item(ACT_READ, '0, '0, '0, 0, 5'd31, 5'd0, 5'd0);
        send_item(ACT_READ, '0, '0, '0, 0, 5'd1, 5'd1, 5'd1);
        send_item(ACT_CLEAR, '1, '1, '1, 1, '1, '1, '1);
        send_item(ACT_READ, '0, '0, '0, 0, 5'd0, 5'd0, 5'd0);
        drain();

        // open mode on a narrow grid, out-of-range reads
        set_regs(0, 3, 32, 5, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_item(ACT_DEPOSIT, pmin, pmin, pmin, 1, '0, '0, '0);
        send_item(ACT_DEPOSIT, pmax, pmax, pmax, 1, '0, '0, '0);
        send_item(ACT_DEPOSIT, 48'h1_8000, 48'h1F_0000, 48'h2_4000, 1, '0, '0, '0);
        send_item(ACT_READ, '0, '0, '0, 0, 5'd0, 5'd0, 5'd0);
        send_item(ACT_READ, '0, '0, '0, 0, 5'd2, 5'd31, 5'd4);
        send_item(ACT_READ, '0, '0, '0, 0, 5'd3, 5'd0, 5'd0);
        send_item(ACT_READ, '0, '0, '0, 0, 5'd1, 5'd31, 5'd5);
        random_items(200);
        drain();

        set_regs(1, 0, 63, 7, 32'h0, 32'hFFFF_FFFF, 32'h0000_8000, 32'h8000_0000);
        random_items(200);
        drain();

        quiet = 1;
        set_regs(0, 32, 4, 0, $urandom, 32'h0004_0000, 32'h0000_0001, 32'h7FFF_FFFF);
        random_items(250);
        drain();
        quiet = 0;

        set_regs(1, 3, 3, 3, 32'h0001_0000, 32'h0002_0000, 32'h0000_4000, 32'hFFFF_0000);
        random_items(200);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            set_regs(1'($urandom), $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 63), $urandom_range(0, 32'h0004_0000),
                     $urandom_range(0, 32'h0004_0000), $urandom, $urandom);
            random_items(200);
            drain();
        end

        $display("covered %0d live deposits, %0d checked reads, %0d grid clears",
                 grid_model.deposits, grid_model.reads, grid_model.clears);
        $display("over 9 register settings in open and periodic modes");
        if (grid_model.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
